FILE: sv/aesd_pkg.sv
// Shared types, constants and byte-level functions for the AES-128 decryptor.
// No dependencies; used by the key expander, the round cell and the top level.
`default_nettype none
package aesd_pkg;

  localparam int unsigned NumRounds  = 10;
  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned BlockWidth = 128;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RndIdxW    = $clog2(NumRounds + 1);

  localparam logic [CfgIdxW-1:0] RegKeyHigh = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegKeyLow  = CfgIdxW'(1);

  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] PolyRed  = 8'h1b;

  typedef logic [BlockWidth-1:0] block_t;
  typedef logic [NumRounds:0][BlockWidth-1:0] rk_set_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? PolyRed : 8'h00);
  endfunction

  // multiply by 14, 11, 13 or 9 for coefficient select 0..3
  function automatic logic [7:0] mul_coef(input logic [7:0] a, input logic [1:0] sel);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    case (sel)
      2'd0:    mul_coef = x8 ^ x4 ^ x2;
      2'd1:    mul_coef = x8 ^ x2 ^ a;
      2'd2:    mul_coef = x8 ^ x4 ^ a;
      2'd3:    mul_coef = x8 ^ a;
      default: mul_coef = 8'h00;
    endcase
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t o;
    logic [1:0] src_c;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src_c = 2'(c - r);
        o[BlockWidth-1-8*(r+4*c) -: 8] = INV_SBOX[s[BlockWidth-1-8*(r+4*int'(src_c)) -: 8]];
      end
    end
    inv_shift_sub = o;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t o;
    logic [7:0] acc;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int d = 0; d < 4; d++) begin
          acc = acc ^ mul_coef(s[BlockWidth-1-8*(d+4*c) -: 8], 2'(d - r));
        end
        o[BlockWidth-1-8*(r+4*c) -: 8] = acc;
      end
    end
    inv_mix = o;
  endfunction

endpackage
`default_nettype wire

FILE: sv/aesd_keyexp.sv
// Key registers and round-key expander: one 128-bit round key per busy cycle.
// Depends on aesd_pkg.
`default_nettype none
module aesd_keyexp
  import aesd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [KeyWidth-1:0] cfg_data_i,
  output rk_set_t                  rk_o,
  output logic                     busy_o
);

  logic [KeyWidth-1:0] key_high_q, key_low_q;
  logic                busy_q;
  logic [RndIdxW-1:0]  cnt_q;
  block_t              cur_q;
  logic [7:0]          rcon_q;
  rk_set_t             rk_q;
  block_t              nxt_d;
  logic [31:0]         t;
  logic [31:0]         w0, w1, w2, w3;
  logic                key_wr;

  assign key_wr = cfg_we_i && (cfg_idx_i == RegKeyHigh || cfg_idx_i == RegKeyLow);

  always_comb begin
    t     = sub_word({cur_q[23:0], cur_q[31:24]}) ^ {rcon_q, 24'h0};
    w0    = cur_q[127:96] ^ t;
    w1    = cur_q[95:64] ^ w0;
    w2    = cur_q[63:32] ^ w1;
    w3    = cur_q[31:0] ^ w2;
    nxt_d = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
    end else if (key_wr) begin
      if (cfg_idx_i == RegKeyHigh) begin
        key_high_q <= cfg_data_i;
      end else begin
        key_low_q <= cfg_data_i;
      end
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + RndIdxW'(1);
      if (cnt_q == RndIdxW'(NumRounds)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !key_wr) begin
      if (cnt_q == '0) begin
        cur_q        <= {key_high_q, key_low_q};
        rk_q[cnt_q]  <= {key_high_q, key_low_q};
        rcon_q       <= RconInit;
      end else begin
        cur_q        <= nxt_d;
        rk_q[cnt_q]  <= nxt_d;
        rcon_q       <= xtime(rcon_q);
      end
    end
  end

  assign rk_o   = rk_q;
  assign busy_o = busy_q;

endmodule
`default_nettype wire

FILE: sv/aesd_cell.sv
// One inverse-cipher round cell: InvShiftRows, InvSubBytes, AddRoundKey, and InvMixColumns unless FinalRound.
// Depends on aesd_pkg; chained ten deep by the top level.
`default_nettype none
module aesd_cell
  import aesd_pkg::*;
#(
  parameter bit FinalRound = 1'b0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   adv_i,
  input  wire ctl_t   ctl_i,
  input  wire block_t state_i,
  input  wire block_t rk_i,
  output ctl_t        ctl_o,
  output block_t      state_o
);

  ctl_t   ctl_q;
  block_t state_q, state_d, mixed;

  always_comb begin
    mixed   = inv_shift_sub(state_i) ^ rk_i;
    state_d = FinalRound ? mixed : inv_mix(mixed);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= state_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

FILE: sv/aes128_block_decrypt.sv
// AES-128 ECB decryptor: input key stage, ten chained round cells, key expander.
// Depends on aesd_pkg, aesd_keyexp and aesd_cell.
//
// Takes one ciphertext block per clock while in_stall_o is low;
// each of the ten round cells plus the initial key-add stage holds one block.
// Stages advance independently, so bubbles close up while the output is stalled.
// A write to key_high or key_low re-expands the schedule, one round key per cycle,
// and in_stall_o stays high while the expansion runs.
`default_nettype none
module aes128_block_decrypt
  import aesd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [KeyWidth-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [KeyWidth-1:0] cipher_high_i,
  input  wire logic [KeyWidth-1:0] cipher_low_i,
  input  wire logic                last_block_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [KeyWidth-1:0]      plain_high_o,
  output logic [KeyWidth-1:0]      plain_low_o,
  output logic                     last_plain_o
);

  rk_set_t                rk;
  logic                   busy;
  logic [NumRounds:0]     adv;
  ctl_t   [NumRounds:0]   ctl;
  block_t [NumRounds:0]   st;
  ctl_t                   ctl0_q, ctl0_d;
  block_t                 st0_q;

  aesd_keyexp u_keyexp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rk_o       (rk),
    .busy_o     (busy)
  );

  always_comb begin
    adv[NumRounds] = !ctl[NumRounds].valid || !out_stall_i;
    for (int k = NumRounds - 1; k >= 0; k--) begin
      adv[k] = !ctl[k].valid || adv[k+1];
    end
  end

  assign in_stall_o   = busy || !adv[0];
  assign ctl0_d.valid = in_valid_i && !busy;
  assign ctl0_d.last  = last_block_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (adv[0]) begin
      ctl0_q <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      st0_q <= {cipher_high_i, cipher_low_i} ^ rk[NumRounds];
    end
  end

  assign ctl[0] = ctl0_q;
  assign st[0]  = st0_q;

  for (genvar j = 0; j < NumRounds; j++) begin : g_cell
    aesd_cell #(
      .FinalRound (j == NumRounds - 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv[j+1]),
      .ctl_i   (ctl[j]),
      .state_i (st[j]),
      .rk_i    (rk[NumRounds-1-j]),
      .ctl_o   (ctl[j+1]),
      .state_o (st[j+1])
    );
  end

  assign out_valid_o  = ctl[NumRounds].valid;
  assign last_plain_o = ctl[NumRounds].last;
  assign plain_high_o = st[NumRounds][BlockWidth-1:KeyWidth];
  assign plain_low_o  = st[NumRounds][KeyWidth-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> in_stall_o)
    else $error("request accepted during key expansion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == RegKeyHigh || cfg_idx_i == RegKeyLow) |=> busy)
    else $error("key write did not start expansion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(plain_high_o)
      && $stable(plain_low_o))
    else $error("stalled result lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl[NumRounds-1].valid && !adv[NumRounds] |-> !adv[NumRounds-1])
    else $error("round stage overwritten while downstream stalled");

endmodule
`default_nettype wire
